@@ src/salf_pkg.sv @@
// shared types and codes for the safety arming lifecycle block
`timescale 1ns / 1ps
`default_nettype none

package salf_pkg;

    // tick counter width
    localparam int TICK_W = 32;
    localparam int GEN_W  = 32;
    localparam int CNT_W  = 32;

    typedef logic [TICK_W-1:0] tick_t;
    typedef logic [GEN_W-1:0]  gen_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // request codes; the spare code behaves as a read
    localparam logic [1:0] REQ_UPDATE = 2'd0;
    localparam logic [1:0] REQ_FAULT  = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;

    typedef enum logic [1:0] {
        MODE_BOOT   = 2'd0,
        MODE_SAFE   = 2'd1,
        MODE_ACTIVE = 2'd2,
        MODE_FAULT  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CAUSE_NONE    = 3'd0,
        CAUSE_BOOT    = 3'd1,
        CAUSE_FATAL   = 3'd2,
        CAUSE_OFFLINE = 3'd3,
        CAUSE_SAFE_SW = 3'd4,
        CAUSE_STARTUP = 3'd5,
        CAUSE_STALE   = 3'd6
    } cause_t;

    // request transaction payload
    typedef struct packed {
        logic [1:0] req_type;
        tick_t      now_ms;
        logic       frame_valid;
        logic       link_online;
        logic       switch_at_safe;
        gen_t       semantics_gen;
        gen_t       authority_gen;
    } req_t;

    // snapshot transaction payload
    typedef struct packed {
        mode_t  cur_mode;
        mode_t  prior_mode;
        cause_t cause;
        logic   drive_enable;
        logic   fault_held;
        logic   online_flag_out;
        logic   safe_flag_out;
        logic   armed_qualified;
        tick_t  entered_at_ms;
        tick_t  updated_at_ms;
        cnt_t   transitions;
    } rsp_t;

endpackage

`default_nettype wire

@@ src/salf_if.sv @@
// valid/ready channel interfaces for requests and snapshots
`timescale 1ns / 1ps
`default_nettype none

interface salf_req_if;
    import salf_pkg::*;

    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface salf_rsp_if;
    import salf_pkg::*;

    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ src/salf_core.sv @@
// arming state machine, tracking marks and snapshot logic
`timescale 1ns / 1ps
`default_nettype none

module salf_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire salf_pkg::req_t  item,
    input  wire logic [31:0]     timeout,
    output salf_pkg::rsp_t       snap
);
    import salf_pkg::*;

    mode_t  mode_reg,       mode_next;
    mode_t  prior_mode_reg, prior_mode_next;
    cause_t cause_reg,      cause_next;
    tick_t  enter_time_reg, enter_time_next;
    tick_t  update_time_reg, update_time_next;
    cnt_t   trans_reg,      trans_next;
    logic   online_reg,     online_next;
    logic   safe_reg,       safe_next;
    logic   enable_reg,     enable_next;
    logic   fault_reg,      fault_next;
    logic   qual_reg,       qual_next;
    gen_t   sem_gen_reg,    sem_gen_next;
    gen_t   auth_gen_reg,   auth_gen_next;

    logic   online;
    logic   safe;
    logic   sem_chg;
    logic   auth_chg;
    logic   qual_upd;
    mode_t  upd_mode;
    cause_t upd_cause;
    tick_t  age;
    logic   stale;

    // frame decode and qualification tracking
    always_comb
    begin
        online   = item.frame_valid & item.link_online;
        safe     = online & item.switch_at_safe;
        sem_chg  = item.frame_valid && (item.semantics_gen != '0)
                   && (item.semantics_gen != sem_gen_reg);
        auth_chg = item.frame_valid && (item.authority_gen != '0)
                   && (item.authority_gen != auth_gen_reg);
        if (safe)
            qual_upd = 1'b1;
        else if (sem_chg || auth_chg)
            qual_upd = 1'b0;
        else
            qual_upd = qual_reg;
    end

    // target state of an update
    always_comb
    begin
        priority if (fault_reg)
        begin
            upd_mode  = MODE_FAULT;
            upd_cause = CAUSE_FATAL;
        end
        else if (!online)
        begin
            upd_mode  = MODE_SAFE;
            upd_cause = CAUSE_OFFLINE;
        end
        else if (safe)
        begin
            upd_mode  = MODE_SAFE;
            upd_cause = CAUSE_SAFE_SW;
        end
        else if (!qual_upd)
        begin
            upd_mode  = MODE_SAFE;
            upd_cause = CAUSE_STARTUP;
        end
        else
        begin
            upd_mode  = MODE_ACTIVE;
            upd_cause = CAUSE_NONE;
        end
    end

    // next state
    always_comb
    begin
        mode_next = mode_reg;
        if (step)
        begin
            unique case (item.req_type)
                REQ_UPDATE: mode_next = upd_mode;
                REQ_FAULT:  mode_next = MODE_FAULT;
                default:    mode_next = mode_reg;
            endcase
        end
    end

    // bookkeeping registers that follow the state change
    always_comb
    begin
        prior_mode_next  = prior_mode_reg;
        cause_next       = cause_reg;
        enter_time_next  = enter_time_reg;
        update_time_next = update_time_reg;
        trans_next       = trans_reg;
        online_next      = online_reg;
        safe_next        = safe_reg;
        enable_next      = enable_reg;
        fault_next       = fault_reg;
        qual_next        = qual_reg;
        sem_gen_next     = sem_gen_reg;
        auth_gen_next    = auth_gen_reg;
        if (step)
        begin
            unique case (item.req_type)
                REQ_UPDATE:
                begin
                    if (upd_mode != mode_reg)
                    begin
                        prior_mode_next = mode_reg;
                        enter_time_next = item.now_ms;
                        trans_next      = trans_reg + 1'b1;
                    end
                    cause_next       = upd_cause;
                    online_next      = online;
                    safe_next        = safe;
                    enable_next      = (upd_mode == MODE_ACTIVE);
                    update_time_next = item.now_ms;
                    qual_next        = qual_upd;
                    if (sem_chg)
                        sem_gen_next = item.semantics_gen;
                    if (auth_chg)
                        auth_gen_next = item.authority_gen;
                end
                REQ_FAULT:
                begin
                    if (mode_reg != MODE_FAULT)
                    begin
                        prior_mode_next = mode_reg;
                        trans_next      = trans_reg + 1'b1;
                    end
                    cause_next       = CAUSE_FATAL;
                    enter_time_next  = item.now_ms;
                    update_time_next = item.now_ms;
                    enable_next      = 1'b0;
                    fault_next       = 1'b1;
                end
                default:
                begin
                    cause_next = cause_reg;
                end
            endcase
        end
    end

    // snapshot with stale lock-out applied on top of the committed state
    always_comb
    begin
        age   = item.now_ms - update_time_next;
        stale = enable_next && (age > timeout);
        snap.prior_mode      = prior_mode_next;
        snap.fault_held      = fault_next;
        snap.armed_qualified = qual_next;
        snap.entered_at_ms   = enter_time_next;
        snap.updated_at_ms   = update_time_next;
        snap.transitions     = trans_next;
        if (stale)
        begin
            snap.cur_mode        = MODE_SAFE;
            snap.cause           = CAUSE_STALE;
            snap.drive_enable    = 1'b0;
            snap.online_flag_out = 1'b0;
            snap.safe_flag_out   = 1'b0;
        end
        else
        begin
            snap.cur_mode        = mode_next;
            snap.cause           = cause_next;
            snap.drive_enable    = enable_next;
            snap.online_flag_out = online_next;
            snap.safe_flag_out   = safe_next;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_BOOT;
            prior_mode_reg  <= MODE_BOOT;
            cause_reg       <= CAUSE_BOOT;
            enter_time_reg  <= '0;
            update_time_reg <= '0;
            trans_reg       <= '0;
            online_reg      <= 1'b0;
            safe_reg        <= 1'b0;
            enable_reg      <= 1'b0;
            fault_reg       <= 1'b0;
            qual_reg        <= 1'b0;
            sem_gen_reg     <= '0;
            auth_gen_reg    <= '0;
        end
        else
        begin
            mode_reg        <= mode_next;
            prior_mode_reg  <= prior_mode_next;
            cause_reg       <= cause_next;
            enter_time_reg  <= enter_time_next;
            update_time_reg <= update_time_next;
            trans_reg       <= trans_next;
            online_reg      <= online_next;
            safe_reg        <= safe_next;
            enable_reg      <= enable_next;
            fault_reg       <= fault_next;
            qual_reg        <= qual_next;
            sem_gen_reg     <= sem_gen_next;
            auth_gen_reg    <= auth_gen_next;
        end
    end

endmodule

`default_nettype wire

@@ src/safety_arming_lifecycle_fsm.sv @@
// Safety arming interlock, top level.
//
// Requests arrive on the req channel (valid/ready); each accepted transaction
// is an update with an operator frame, a fatal fault, or a snapshot read.
// Every request returns exactly one snapshot transaction on the rsp channel.
// The stale timeout (cfg_we/cfg_wdata, reset to 100 ms) is to be written by the
// user only while the block is idle; the block itself does not enforce this.
//
// A request is captured in the input register; the state update, stale check and
// snapshot are then done in one pass and land in the output register. Throughput
// is one transaction per cycle while the receiver does not stall, set by that
// single pass through the state logic.
//
// Reset puts the block in boot mode with all marks, stamps and counters
// cleared. When the receiver stalls, the snapshot holds in the output
// register and the captured request waits in the input register. Once both
// registers are occupied, req.ready drops in the same cycle as rsp.ready,
// so at most two transactions are held inside the block.
`timescale 1ns / 1ps
`default_nettype none

module safety_arming_lifecycle_fsm (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    cfg_we,
    input  wire logic [31:0] cfg_wdata,
    salf_req_if.sink     req,
    salf_rsp_if.source   rsp
);
    import salf_pkg::*;

    logic [31:0] timeout_reg;
    logic        in_valid_reg, in_valid_next;
    req_t        in_item_reg;
    logic        out_valid_reg, out_valid_next;
    rsp_t        out_item_reg;
    logic        advance;
    rsp_t        snap;

    // handshake control
    always_comb
    begin
        advance        = in_valid_reg && (!out_valid_reg || rsp.ready);
        req.ready      = !in_valid_reg || advance;
        in_valid_next  = req.valid ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_item_reg;

    // state machine and snapshot
    salf_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .item    (in_item_reg),
        .timeout (timeout_reg),
        .snap    (snap)
    );

    // control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg   <= 32'd100;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                timeout_reg <= cfg_wdata;
            if (req.ready)
                in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
            in_item_reg <= req.payload;
        if (advance)
            out_item_reg <= snap;
    end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench for the safety arming lifecycle block with its own snapshot predictor
`timescale 1ns / 1ps

module tb;
    import salf_pkg::*;

    // spare request code, behaves as a snapshot read
    localparam logic [1:0] REQ_SPARE = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    salf_req_if req_ch ();
    salf_rsp_if rsp_ch ();

    safety_arming_lifecycle_fsm uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // interlock state as predicted
    mode_t  arm_mode    = MODE_BOOT;
    mode_t  arm_prior   = MODE_BOOT;
    cause_t arm_cause   = CAUSE_BOOT;
    tick_t  arm_enter   = '0;
    tick_t  arm_update  = '0;
    cnt_t   arm_trans   = '0;
    logic   arm_online  = 1'b0;
    logic   arm_safe    = 1'b0;
    logic   arm_enable  = 1'b0;
    logic   arm_fault   = 1'b0;
    logic   arm_qual    = 1'b0;
    gen_t   arm_sgen    = '0;
    gen_t   arm_agen    = '0;
    tick_t  arm_timeout = 32'd100;

    // stimulus and scoreboard storage
    req_t pending_q[$];
    rsp_t snap_q[$];
    rsp_t snap_want;
    rsp_t snap_got;

    // stimulus generator state
    tick_t gen_clock = '0;
    gen_t  cur_sgen  = '0;
    gen_t  cur_agen  = '0;

    // handshake and idling control
    logic req_fire       = 1'b0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   stall_goal     = 0;
    int   stall_done     = 0;

    // run statistics
    int mismatches = 0;
    int n_req      = 0;
    int n_snap     = 0;
    int n_active   = 0;
    int n_stale    = 0;
    int n_faulted  = 0;

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // snapshot prediction for one accepted request transaction
    function automatic rsp_t arm_predict(input req_t r);
        rsp_t   s;
        logic   online;
        logic   safe_now;
        mode_t  nxt;
        cause_t why;
        tick_t  age;
        if (r.req_type == REQ_UPDATE)
        begin
            online   = r.frame_valid & r.link_online;
            safe_now = online & r.switch_at_safe;
            // generation change revokes the qualification, safe position grants it
            if (r.frame_valid && r.semantics_gen != '0 && r.semantics_gen != arm_sgen)
            begin
                arm_sgen = r.semantics_gen;
                arm_qual = 1'b0;
            end
            if (r.frame_valid && r.authority_gen != '0 && r.authority_gen != arm_agen)
            begin
                arm_agen = r.authority_gen;
                arm_qual = 1'b0;
            end
            if (safe_now)
                arm_qual = 1'b1;
            if (arm_fault)
            begin
                nxt = MODE_FAULT;
                why = CAUSE_FATAL;
            end
            else if (!online)
            begin
                nxt = MODE_SAFE;
                why = CAUSE_OFFLINE;
            end
            else if (safe_now)
            begin
                nxt = MODE_SAFE;
                why = CAUSE_SAFE_SW;
            end
            else if (!arm_qual)
            begin
                nxt = MODE_SAFE;
                why = CAUSE_STARTUP;
            end
            else
            begin
                nxt = MODE_ACTIVE;
                why = CAUSE_NONE;
            end
            if (arm_mode != nxt)
            begin
                arm_prior = arm_mode;
                arm_mode  = nxt;
                arm_enter = r.now_ms;
                arm_trans = arm_trans + 1'b1;
            end
            arm_cause  = why;
            arm_online = online;
            arm_safe   = safe_now;
            arm_enable = (nxt == MODE_ACTIVE);
            arm_update = r.now_ms;
        end
        else if (r.req_type == REQ_FAULT)
        begin
            // fault always restamps, counts only a real change
            if (arm_mode != MODE_FAULT)
            begin
                arm_prior = arm_mode;
                arm_trans = arm_trans + 1'b1;
            end
            arm_mode   = MODE_FAULT;
            arm_cause  = CAUSE_FATAL;
            arm_enter  = r.now_ms;
            arm_update = r.now_ms;
            arm_enable = 1'b0;
            arm_fault  = 1'b1;
        end
        s.cur_mode        = arm_mode;
        s.prior_mode      = arm_prior;
        s.cause           = arm_cause;
        s.drive_enable    = arm_enable;
        s.fault_held      = arm_fault;
        s.online_flag_out = arm_online;
        s.safe_flag_out   = arm_safe;
        s.armed_qualified = arm_qual;
        s.entered_at_ms   = arm_enter;
        s.updated_at_ms   = arm_update;
        s.transitions     = arm_trans;
        // stale lock-out masks the output only
        age = r.now_ms - arm_update;
        if (arm_enable && age > arm_timeout)
        begin
            s.cur_mode        = MODE_SAFE;
            s.cause           = CAUSE_STALE;
            s.drive_enable    = 1'b0;
            s.online_flag_out = 1'b0;
            s.safe_flag_out   = 1'b0;
        end
        return s;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            $error("snapshot field %0s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            mismatches++;
        end
    endfunction

    // random request with timestamps spread around the stale threshold
    function automatic req_t random_item(input bit allow_fault);
        req_t        it;
        int unsigned r;
        int unsigned d;
        r = $urandom_range(0, 99);
        if (r < 35)
            d = $urandom_range(0, 3);
        else if (r < 60)
            d = $urandom_range(0, 60);
        else if (r < 75)
            d = (arm_timeout <= 100000) ? $urandom_range(0, arm_timeout * 2 + 1)
                                        : $urandom_range(0, 1000);
        else if (r < 88)
            d = arm_timeout + $urandom_range(0, 1);
        else if (r < 95)
            d = $urandom;
        else
            d = 0 - $urandom_range(1, 5);
        gen_clock = gen_clock + d;
        it.now_ms = gen_clock;
        r = $urandom_range(0, 99);
        if (allow_fault && r < 3)
            it.req_type = REQ_FAULT;
        else if (r < 70)
            it.req_type = REQ_UPDATE;
        else if (r < 93)
            it.req_type = REQ_READ;
        else
            it.req_type = REQ_SPARE;
        it.frame_valid    = ($urandom_range(0, 99) < 94);
        it.link_online    = ($urandom_range(0, 99) < 90);
        it.switch_at_safe = ($urandom_range(0, 99) < 22);
        // generations mostly steady, sometimes bumped or replaced
        r = $urandom_range(0, 99);
        if (r < 4)
            cur_sgen = $urandom;
        else if (r < 8)
            cur_sgen = cur_sgen + 1'b1;
        r = $urandom_range(0, 99);
        if (r < 4)
            cur_agen = $urandom;
        else if (r < 8)
            cur_agen = cur_agen + 1'b1;
        it.semantics_gen = ($urandom_range(0, 99) < 6) ? '0 : cur_sgen;
        it.authority_gen = ($urandom_range(0, 99) < 6) ? '0 : cur_agen;
        // ignored generation fields get pure noise
        if (!it.frame_valid || it.req_type != REQ_UPDATE)
        begin
            it.semantics_gen = $urandom;
            it.authority_gen = $urandom;
        end
        return it;
    endfunction

    task automatic push_req(input logic [1:0] kind, input tick_t at, input logic fv,
                            input logic lo, input logic sw, input gen_t sg, input gen_t ag);
        req_t it;
        it.req_type       = kind;
        it.now_ms         = at;
        it.frame_valid    = fv;
        it.link_online    = lo;
        it.switch_at_safe = sw;
        it.semantics_gen  = sg;
        it.authority_gen  = ag;
        gen_clock         = at;
        pending_q.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || snap_q.size() != 0 || req_ch.valid)
            @(negedge clk);
    endtask

    task automatic write_timeout(input tick_t v);
        @(negedge clk);
        cfg_we      <= 1'b1;
        cfg_wdata   <= v;
        arm_timeout = v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // one configuration setting followed by a batch of random requests
    task automatic run_phase(input tick_t lim, input int mode, input int count,
                             input bit with_faults, input bit mid_pause);
        wait_drained();
        repeat (4) @(negedge clk);
        write_timeout(lim);
        case (mode)
            0:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct  = 73;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 73;
            end
            default:
            begin
                send_idle_pct  = 26;
                recv_stall_pct = 26;
            end
        endcase
        for (int i = 0; i < count; i++)
        begin
            if (mid_pause && i == count / 2)
                wait_drained();
            pending_q.push_back(random_item(with_faults));
        end
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (!req_ch.valid || req_fire)
        begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                req_ch.payload <= pending_q.pop_front();
                req_ch.valid   <= 1'b1;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // snapshot receiver with random stalls and long hold-offs
    always @(negedge clk)
    begin
        if (stall_done < stall_goal)
        begin
            rsp_ch.ready <= 1'b0;
            stall_done++;
        end
        else
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor: predict on request, compare on snapshot
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_fire = req_ch.valid && req_ch.ready;
            if (req_fire)
            begin
                snap_q.push_back(arm_predict(req_ch.payload));
                n_req++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                snap_got = rsp_ch.payload;
                if (snap_q.size() == 0)
                begin
                    $error("snapshot transaction with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    snap_want = snap_q.pop_front();
                    n_snap++;
                    if (snap_want.cur_mode == MODE_ACTIVE)
                        n_active++;
                    if (snap_want.cause == CAUSE_STALE)
                        n_stale++;
                    if (snap_want.fault_held)
                        n_faulted++;
                    check_field("cur_mode", snap_want.cur_mode, snap_got.cur_mode);
                    check_field("prior_mode", snap_want.prior_mode, snap_got.prior_mode);
                    check_field("cause", snap_want.cause, snap_got.cause);
                    check_field("drive_enable", snap_want.drive_enable,
                                snap_got.drive_enable);
                    check_field("fault_held", snap_want.fault_held, snap_got.fault_held);
                    check_field("online_flag_out", snap_want.online_flag_out,
                                snap_got.online_flag_out);
                    check_field("safe_flag_out", snap_want.safe_flag_out,
                                snap_got.safe_flag_out);
                    check_field("armed_qualified", snap_want.armed_qualified,
                                snap_got.armed_qualified);
                    check_field("entered_at_ms", snap_want.entered_at_ms,
                                snap_got.entered_at_ms);
                    check_field("updated_at_ms", snap_want.updated_at_ms,
                                snap_got.updated_at_ms);
                    check_field("transitions", snap_want.transitions, snap_got.transitions);
                end
            end
        end
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // sequence of phases
    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready   = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed opening at the reset timeout
        push_req(REQ_READ, 32'd0, 1'b0, 1'b0, 1'b0, '0, '0);
        // missing frame ignores its generation fields
        push_req(REQ_UPDATE, 32'd5, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
        // safe switch without link
        push_req(REQ_UPDATE, 32'd10, 1'b1, 1'b0, 1'b1, '0, '0);
        push_req(REQ_UPDATE, 32'd20, 1'b1, 1'b1, 1'b0, '0, '0);
        push_req(REQ_UPDATE, 32'd30, 1'b1, 1'b1, 1'b1, '0, '0);
        push_req(REQ_UPDATE, 32'd40, 1'b1, 1'b1, 1'b0, '0, '0);
        // age right at and just past the timeout
        push_req(REQ_READ, 32'd140, 1'b0, 1'b0, 1'b0, '0, '0);
        push_req(REQ_SPARE, 32'd141, 1'b0, 1'b0, 1'b0, '0, '0);
        push_req(REQ_READ, 32'd141, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // generation changes revoke, zero generations do not
        push_req(REQ_UPDATE, 32'd150, 1'b1, 1'b1, 1'b0, 32'd5, '0);
        push_req(REQ_UPDATE, 32'd160, 1'b1, 1'b1, 1'b1, 32'd5, 32'd7);
        push_req(REQ_UPDATE, 32'd170, 1'b1, 1'b1, 1'b0, 32'd5, 32'd7);
        push_req(REQ_UPDATE, 32'd180, 1'b1, 1'b1, 1'b0, '0, '0);
        // all-ones generations and tick wrap
        push_req(REQ_UPDATE, 32'hFFFF_FFF0, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(REQ_UPDATE, 32'hFFFF_FFF8, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(REQ_UPDATE, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(REQ_READ, 32'h0000_0063, 1'b0, 1'b0, 1'b0, '0, '0);
        push_req(REQ_READ, 32'h0000_0064, 1'b0, 1'b0, 1'b0, '0, '0);
        push_req(REQ_UPDATE, 32'h0000_0070, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(REQ_UPDATE, 32'h0000_0080, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        cur_sgen = 32'hFFFF_FFFF;
        cur_agen = 32'hFFFF_FFFF;

        // random phases over several timeouts and idling patterns
        run_phase(32'd250, 0, 160, 1'b0, 1'b0);
        stall_goal = stall_goal + 300;
        run_phase(32'd0, 1, 160, 1'b0, 1'b0);
        gen_clock = 32'hFFFF_FF00;
        run_phase(32'hFFFF_FFFF, 2, 160, 1'b0, 1'b1);
        run_phase(32'd20, 3, 160, 1'b0, 1'b0);
        run_phase(32'd100, 0, 160, 1'b0, 1'b0);
        run_phase(32'd3, 1, 160, 1'b0, 1'b0);

        // fault latch: arm, fault, repeated fault, activity while latched
        wait_drained();
        push_req(REQ_UPDATE, gen_clock + 1, 1'b1, 1'b1, 1'b1, cur_sgen, cur_agen);
        push_req(REQ_UPDATE, gen_clock + 1, 1'b1, 1'b1, 1'b0, cur_sgen, cur_agen);
        push_req(REQ_FAULT, gen_clock + 1, 1'b1, 1'b1, 1'b1, cur_sgen, cur_agen);
        push_req(REQ_FAULT, gen_clock + 2, 1'b0, 1'b0, 1'b0, '0, '0);
        push_req(REQ_UPDATE, gen_clock + 1, 1'b1, 1'b1, 1'b1, cur_sgen + 1'b1, cur_agen);
        push_req(REQ_READ, gen_clock + 500, 1'b0, 1'b0, 1'b0, '0, '0);
        push_req(REQ_SPARE, gen_clock + 1, 1'b0, 1'b0, 1'b0, '0, '0);
        push_req(REQ_UPDATE, gen_clock + 1, 1'b0, 1'b0, 1'b0, '0, '0);
        run_phase(32'h7FFF_FFFF, 3, 80, 1'b1, 1'b0);

        wait_drained();
        repeat (10) @(negedge clk);
        $display("tb: %0d requests over seven timeout settings, %0d snapshots checked",
                 n_req, n_snap);
        $display("tb: %0d active, %0d stale lock-out, %0d with fault latched",
                 n_active, n_stale, n_faulted);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
